@@ rtl/core/dwq_pkg.sv @@
`default_nettype none

package dwq_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [7:0] elem_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_DUP   = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/dedup_work_queue.sv @@
// Channel  Signals                                   Direction
// input    in_valid, in_ready, operation, element_id  into the block
// output   out_valid, out_ready, status, removed_id,  out of the block
//          not_empty
//
// For add, remove and the unused code, the flag and link memories are read in
// the accept cycle and written back in the result cycle.
// Clear walks the link memory one entry per cycle and clears the flag of each
// queued element.
// After reset the flag memory is swept to zero before the first word is accepted.
// A stalled output holds the result cycle; the next word is taken only after it.
`default_nettype none

module dedup_work_queue #(
  parameter int ELEMENT_COUNT = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire dwq_pkg::op_t    operation,
  input  wire dwq_pkg::elem_t  element_id,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      dwq_pkg::status_t status,
  output      dwq_pkg::elem_t  removed_id,
  output      logic            not_empty
);

  import dwq_pkg::*;

  localparam int IW = $clog2(ELEMENT_COUNT);
  localparam logic [IW-1:0] LAST = IW'(ELEMENT_COUNT - 1);

  state_t state, state_next;
  logic [IW-1:0] init_cnt, init_cnt_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] walk, walk_next;
  logic nonempty, nonempty_next;
  op_t op_q;
  elem_t id_q;
  logic in_range_q;

  logic f_we, f_wdata, f_re, f_rdata;
  logic [IW-1:0] f_waddr, f_raddr;
  logic l_we, l_re;
  logic [IW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;

  logic load_out, accept;
  status_t res_status;
  elem_t res_id;

  logic [IW-1:0] id_idx, id_q_idx;

  assign id_idx   = IW'(element_id);
  assign id_q_idx = IW'(id_q);
  assign accept   = in_valid && in_ready;

  dwq_ram #(.WIDTH(1), .DEPTH(ELEMENT_COUNT)) u_flags (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  dwq_ram #(.WIDTH(IW), .DEPTH(ELEMENT_COUNT)) u_links (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  always_comb begin
    state_next    = state;
    init_cnt_next = init_cnt;
    head_next     = head;
    tail_next     = tail;
    walk_next     = walk;
    nonempty_next = nonempty;
    in_ready      = 1'b0;
    f_we          = 1'b0;
    f_waddr       = walk;
    f_wdata       = 1'b0;
    f_re          = 1'b0;
    f_raddr       = id_idx;
    l_we          = 1'b0;
    l_waddr       = tail;
    l_wdata       = id_q_idx;
    l_re          = 1'b0;
    l_raddr       = head;
    load_out      = 1'b0;
    res_status    = ST_DONE;
    res_id        = '0;
    case (state)
      S_INIT: begin
        f_we          = 1'b1;
        f_waddr       = init_cnt;
        init_cnt_next = init_cnt + 1'b1;
        if (init_cnt == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          f_re      = 1'b1;
          l_re      = 1'b1;
          walk_next = head;
          if (operation == OP_CLEAR && nonempty) begin
            state_next = S_WALK;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_WALK: begin
        f_we = 1'b1;
        if (walk == tail) begin
          state_next = S_RESP;
        end else begin
          l_re      = 1'b1;
          l_raddr   = l_rdata;
          walk_next = l_rdata;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_ADD: begin
              if (!in_range_q || f_rdata) begin
                res_status = ST_DUP;
              end else begin
                f_we    = 1'b1;
                f_waddr = id_q_idx;
                f_wdata = 1'b1;
                if (nonempty) begin
                  l_we = 1'b1;
                end else begin
                  head_next = id_q_idx;
                end
                tail_next     = id_q_idx;
                nonempty_next = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (!nonempty) begin
                res_status = ST_EMPTY;
              end else begin
                f_we    = 1'b1;
                f_waddr = head;
                res_id  = 8'(head);
                if (head == tail) begin
                  nonempty_next = 1'b0;
                end else begin
                  head_next = l_rdata;
                end
              end
            end
            OP_CLEAR: begin
              nonempty_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      head      <= '0;
      tail      <= '0;
      nonempty  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      init_cnt <= init_cnt_next;
      head     <= head_next;
      tail     <= tail_next;
      nonempty <= nonempty_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (accept) begin
      op_q       <= operation;
      id_q       <= element_id;
      in_range_q <= (32'(element_id) < 32'(ELEMENT_COUNT));
    end
    if (load_out) begin
      status     <= res_status;
      removed_id <= res_id;
      not_empty  <= nonempty_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dwq_ram.sv @@
`default_nettype none

module dwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dwq_checker.sv @@
`default_nettype none

module dwq_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire dwq_pkg::op_t     operation,
  input wire dwq_pkg::elem_t   element_id,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire dwq_pkg::status_t status,
  input wire dwq_pkg::elem_t   removed_id,
  input wire logic             not_empty
);

  import dwq_pkg::*;

  a_empty_reports_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> !not_empty && removed_id == '0)
    else $error("remove on empty list reported a non-empty list or an id");

  a_dup_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DUP |-> removed_id == '0)
    else $error("ignored add reported a removed id");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("a second word was taken while one was in flight");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(element_id))
    else $error("waiting input word changed or was withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(removed_id) && $stable(not_empty))
    else $error("stalled result changed");

endmodule

bind dedup_work_queue dwq_checker u_dwq_checker (.*);

`default_nettype wire

@@ dv/dwq_list_checker.sv @@
`default_nettype none

module dwq_list_checker
  import dwq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_ready,
  input  wire op_t     operation,
  input  wire elem_t   element_id,
  input  wire logic    out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  input  wire elem_t   removed_id,
  input  wire logic    not_empty,
  output int           errors,
  output int           outstanding,
  output int           compared,
  output int           peak_len
);

  localparam int ELEMENTS = 256;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    status_t st;
    elem_t   id;
    logic    ne;
  } reply_t;

  reply_t replies[$];
  elem_t  links [ELEMENTS];
  bit     queued[ELEMENTS];
  elem_t  head;
  elem_t  tail;
  bit     nonempty;
  int     length;
  int     n_err;
  int     n_cmp;
  int     n_peak;

  function automatic reply_t apply_list_op(input op_t op, input elem_t id);
    reply_t r;
    elem_t  walk;
    bit     done;
    r.st = ST_DONE;
    r.id = '0;
    case (op)
      OP_ADD: begin
        if (queued[id]) begin
          r.st = ST_DUP;
        end else begin
          queued[id] = 1'b1;
          if (!nonempty) begin
            head = id;
            nonempty = 1'b1;
          end else begin
            links[tail] = id;
          end
          tail = id;
          length++;
        end
      end
      OP_REMOVE: begin
        if (!nonempty) begin
          r.st = ST_EMPTY;
        end else begin
          r.id = head;
          queued[head] = 1'b0;
          length--;
          if (head == tail) nonempty = 1'b0;
          else head = links[head];
        end
      end
      OP_CLEAR: begin
        walk = head;
        done = !nonempty;
        for (int steps = 0; steps < ELEMENTS && !done; steps++) begin
          queued[walk] = 1'b0;
          if (walk == tail) done = 1'b1;
          else walk = links[walk];
        end
        nonempty = 1'b0;
        length = 0;
      end
      default: begin
      end
    endcase
    r.ne = nonempty;
    return r;
  endfunction

  task automatic note_failure(input string what, input reply_t want);
    n_err++;
    if (n_err <= SHOWN_MISMATCHES) begin
      $display("%s: expected status %0d removed_id %0d not_empty %0d, got %0d %0d %0d",
               what, want.st, want.id, want.ne, status, removed_id, not_empty);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      replies.delete();
      for (int k = 0; k < ELEMENTS; k++) begin
        queued[k] = 1'b0;
        links[k] = '0;
      end
      head = '0;
      tail = '0;
      nonempty = 1'b0;
      length = 0;
      n_err = 0;
      n_cmp = 0;
      n_peak = 0;
    end else begin
      if (in_valid && in_ready) begin
        replies.push_back(apply_list_op(operation, element_id));
      end
      if (out_valid && out_ready) begin
        if (replies.size() == 0) begin
          note_failure("Result word with nothing expected", '0);
        end else begin
          want = replies.pop_front();
          n_cmp++;
          if (status !== want.st || removed_id !== want.id || not_empty !== want.ne) begin
            note_failure("Result word mismatch", want);
          end
        end
      end
      if (length > n_peak) n_peak = length;
    end
    errors <= n_err;
    compared <= n_cmp;
    peak_len <= n_peak;
    outstanding <= replies.size();
  end

endmodule

`default_nettype wire

@@ dv/tb_dedup_work_queue.sv @@
`default_nettype none

module tb_dedup_work_queue;
  import dwq_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIRECTED = 21;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  op_t     operation = OP_ADD;
  elem_t   element_id = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  status_t status;
  elem_t   removed_id;
  logic    not_empty;

  int errors;
  int outstanding;
  int compared;
  int peak_len;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int sent[4] = '{0, 0, 0, 0};

  op_t dir_ops[DIRECTED] = '{
    OP_REMOVE, OP_CLEAR, OP_UNUSED, OP_ADD, OP_ADD, OP_ADD, OP_ADD,
    OP_UNUSED, OP_REMOVE, OP_REMOVE, OP_ADD, OP_REMOVE, OP_REMOVE, OP_REMOVE,
    OP_ADD, OP_ADD, OP_ADD, OP_CLEAR, OP_ADD, OP_ADD, OP_REMOVE
  };
  elem_t dir_ids[DIRECTED] = '{
    8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80,
    8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
    8'hAA, 8'h55, 8'h01, 8'hFF, 8'h55, 8'h55, 8'h00
  };

  dedup_work_queue dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .element_id (element_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .removed_id (removed_id),
    .not_empty  (not_empty)
  );

  dwq_list_checker list_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .element_id  (element_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .removed_id  (removed_id),
    .not_empty   (not_empty),
    .errors      (errors),
    .outstanding (outstanding),
    .compared    (compared),
    .peak_len    (peak_len)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input elem_t id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    element_id <= id;
    sent[op]++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic fill_every_element();
    elem_t order[256];
    elem_t swap;
    int    j;
    for (int k = 0; k < 256; k++) order[k] = elem_t'(k);
    for (int k = 255; k > 0; k--) begin
      j = $urandom_range(k);
      swap = order[k];
      order[k] = order[j];
      order[j] = swap;
    end
    for (int k = 0; k < 256; k++) send_word(OP_ADD, order[k]);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    bit    add_heavy;
    int    pick;
    op_t   op;
    elem_t id;
    send_idle_pct = idle;
    stall_pct = stall;
    add_heavy = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) add_heavy = $urandom_range(1);
      pick = $urandom_range(99);
      if (add_heavy) begin
        op = (pick < 65) ? OP_ADD : (pick < 88) ? OP_REMOVE : (pick < 94) ? OP_CLEAR : OP_UNUSED;
      end else begin
        op = (pick < 35) ? OP_ADD : (pick < 85) ? OP_REMOVE : (pick < 92) ? OP_CLEAR : OP_UNUSED;
      end
      id = ($urandom_range(3) == 0) ? elem_t'($urandom_range(15)) : elem_t'($urandom_range(255));
      send_word(op, id);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < DIRECTED; k++) send_word(dir_ops[k], dir_ids[k]);
    fill_every_element();
    run_phase(0, 0, 310);
    run_phase(60, 0, 310);
    run_phase(0, 60, 310);
    run_phase(28, 28, 310);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d adds, %0d removes, %0d clears and %0d unused-code words.",
             sent[OP_ADD], sent[OP_REMOVE], sent[OP_CLEAR], sent[OP_UNUSED]);
    $display("Checked %0d results; the list peaked at %0d queued elements; %0d failures.",
             compared, peak_len, errors + outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/dwq_pkg.sv
rtl/core/dwq_ram.sv
rtl/core/dedup_work_queue.sv
rtl/core/dwq_checker.sv
dv/dwq_list_checker.sv
dv/tb_dedup_work_queue.sv
